### hdl/pgn_pkg.sv
// shared types, codes and character classes for the pgn token scanner
package pgn_pkg;

    localparam int DEPTH_MAX = 255;
    localparam int DepthWidth = $clog2(DEPTH_MAX + 1);
    localparam int LenWidth = 9;
    localparam logic [LenWidth-1:0] MaxLenReset = 9'd300;
    localparam int FifoDepth = 4;
    localparam int FifoPtrWidth = $clog2(FifoDepth);
    localparam int FifoCntWidth = $clog2(FifoDepth + 1);

    localparam logic [7:0] CharQuote = 8'h22;
    localparam logic [7:0] CharBackslash = 8'h5c;
    localparam logic [7:0] CharSemicolon = 8'h3b;
    localparam logic [7:0] CharBraceOpen = 8'h7b;
    localparam logic [7:0] CharBraceClose = 8'h7d;
    localparam logic [7:0] CharParenOpen = 8'h28;
    localparam logic [7:0] CharParenClose = 8'h29;
    localparam logic [7:0] CharLf = 8'h0a;
    localparam logic [7:0] CharCr = 8'h0d;

    typedef enum logic [6:0] {
        MODE_IDLE      = 7'b0000001,
        MODE_SYMBOL    = 7'b0000010,
        MODE_STRING    = 7'b0000100,
        MODE_ESCAPE    = 7'b0001000,
        MODE_LINE      = 7'b0010000,
        MODE_BRACE     = 7'b0100000,
        MODE_VARIATION = 7'b1000000
    } mode_t;

    typedef enum logic [1:0] {
        RK_CHAR  = 2'd0,
        RK_EMPTY = 2'd1,
        RK_ERROR = 2'd2,
        RK_EOI   = 2'd3
    } result_kind_t;

    typedef enum logic [1:0] {
        TK_SYMBOL = 2'd0,
        TK_STRING = 2'd1,
        TK_PUNCT  = 2'd2
    } token_kind_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_input;
    } item_t;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [1:0] token_kind;
        logic [7:0] token_char;
        logic       token_end;
        logic       last;
    } result_t;

    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'd32, [8'd9:8'd13]};
    endfunction

    function automatic logic is_symbol_char(input logic [7:0] c);
        return c inside {["a":"z"], ["A":"Z"], ["0":"9"],
                         "_", "+", "#", "=", ":", "-", "/", "$"};
    endfunction

    function automatic result_t mk_result(input result_kind_t rk, input token_kind_t tk,
                                          input logic [7:0] ch, input logic token_end);
        result_t r;
        r.result_kind = rk;
        r.token_kind = tk;
        r.token_char = ch;
        r.token_end = token_end;
        r.last = 1'b0;
        return r;
    endfunction

endpackage

### hdl/pgn_token_scanner_top.sv
// pgn token scanner: byte stream in, tagged token characters out
//
// item channel: one byte or an end-of-input mark per transaction (item_valid,
//   item_stall, item). a transaction completes when valid is high and stall low.
// result channel: token characters, empty-string, syntax-error and end-of-input
//   results (result_valid, result_stall, result); last marks the final result
//   of one input transaction.
// cfg_write_en / cfg_data write max_token_length; write only while idle.
// each accepted item is scanned in the cycle it is accepted and gives zero,
//   one or two results into a four-entry result queue; a result is registered
//   in the queue and shows on the result channel from the queue head.
// throughput: one item per cycle while the result side keeps up; an item
//   that gives two results needs two result transactions. item_stall rises
//   when the queue has fewer than two free entries.
// reset: idle between tokens, queue empty, max_token_length 300.
// a stalled result holds; the queue fills and then stalls the item side.
module pgn_token_scanner_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_stall,
    input  pgn_pkg::item_t                    item,
    output logic                              result_valid,
    input  logic                              result_stall,
    output pgn_pkg::result_t                  result,
    input  logic                              cfg_write_en,
    input  logic [pgn_pkg::LenWidth-1:0]      cfg_data
);

    pgn_pkg::mode_t                       mode_reg, mode_next;
    logic [pgn_pkg::LenWidth-1:0]         count_reg, count_next;
    logic [7:0]                           held_char_reg, held_char_next;
    logic                                 held_valid_reg, held_valid_next;
    logic [pgn_pkg::DepthWidth-1:0]       depth_reg, depth_next;
    logic [pgn_pkg::LenWidth-1:0]         max_len_reg;

    pgn_pkg::result_t                     fifo_reg [pgn_pkg::FifoDepth];
    logic [pgn_pkg::FifoPtrWidth-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [pgn_pkg::FifoPtrWidth-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [pgn_pkg::FifoCntWidth-1:0]     fill_reg, fill_next;

    pgn_pkg::result_t                     res_slot [2];
    logic [1:0]                           res_count;
    logic                                 do_store;
    logic                                 do_start;
    logic                                 accept_item;
    logic                                 pop;
    logic [7:0]                           c;
    pgn_pkg::token_kind_t                 held_tk;

    assign accept_item = item_valid && !item_stall;
    assign item_stall = fill_reg > pgn_pkg::FifoCntWidth'(pgn_pkg::FifoDepth - 2);
    assign result_valid = fill_reg != '0;
    assign result = fifo_reg[rd_ptr_reg];
    assign pop = result_valid && !result_stall;
    assign c = item.char_in;

    always_comb
    begin
        mode_next = mode_reg;
        count_next = count_reg;
        held_char_next = held_char_reg;
        held_valid_next = held_valid_reg;
        depth_next = depth_reg;
        res_slot[0] = '0;
        res_slot[1] = '0;
        res_count = 2'd0;
        do_store = 1'b0;
        do_start = 1'b0;
        held_tk = pgn_pkg::TK_SYMBOL;

        if (item.end_of_input)
        begin
            case (mode_reg)
                pgn_pkg::MODE_SYMBOL:
                begin
                    if (held_valid_reg)
                    begin
                        res_slot[res_count[0]] = pgn_pkg::mk_result(pgn_pkg::RK_CHAR,
                            pgn_pkg::TK_SYMBOL, held_char_reg, 1'b1);
                        res_count = res_count + 2'd1;
                    end
                    res_slot[res_count[0]] = pgn_pkg::mk_result(pgn_pkg::RK_EOI,
                        pgn_pkg::TK_SYMBOL, 8'd0, 1'b0);
                    res_count = res_count + 2'd1;
                end
                pgn_pkg::MODE_STRING, pgn_pkg::MODE_ESCAPE:
                begin
                    res_slot[0] = pgn_pkg::mk_result(pgn_pkg::RK_ERROR,
                        pgn_pkg::TK_SYMBOL, 8'd0, 1'b0);
                    res_count = 2'd1;
                end
                default:
                begin
                    res_slot[0] = pgn_pkg::mk_result(pgn_pkg::RK_EOI,
                        pgn_pkg::TK_SYMBOL, 8'd0, 1'b0);
                    res_count = 2'd1;
                end
            endcase
            mode_next = pgn_pkg::MODE_IDLE;
            count_next = '0;
            held_char_next = 8'd0;
            held_valid_next = 1'b0;
            depth_next = '0;
        end
        else
        begin
            case (mode_reg)
                pgn_pkg::MODE_SYMBOL:
                begin
                    if (pgn_pkg::is_symbol_char(c))
                    begin
                        do_store = 1'b1;
                    end
                    else
                    begin
                        if (held_valid_reg)
                        begin
                            res_slot[0] = pgn_pkg::mk_result(pgn_pkg::RK_CHAR,
                                pgn_pkg::TK_SYMBOL, held_char_reg, 1'b1);
                            res_count = 2'd1;
                        end
                        do_start = 1'b1;
                    end
                end
                pgn_pkg::MODE_STRING:
                begin
                    if (c == pgn_pkg::CharQuote)
                    begin
                        if (held_valid_reg)
                        begin
                            res_slot[0] = pgn_pkg::mk_result(pgn_pkg::RK_CHAR,
                                pgn_pkg::TK_STRING, held_char_reg, 1'b1);
                        end
                        else
                        begin
                            res_slot[0] = pgn_pkg::mk_result(pgn_pkg::RK_EMPTY,
                                pgn_pkg::TK_STRING, 8'd0, 1'b1);
                        end
                        res_count = 2'd1;
                        mode_next = pgn_pkg::MODE_IDLE;
                        count_next = '0;
                        held_char_next = 8'd0;
                        held_valid_next = 1'b0;
                    end
                    else if (c == pgn_pkg::CharBackslash)
                    begin
                        mode_next = pgn_pkg::MODE_ESCAPE;
                    end
                    else
                    begin
                        do_store = 1'b1;
                    end
                end
                pgn_pkg::MODE_ESCAPE:
                begin
                    mode_next = pgn_pkg::MODE_STRING;
                    do_store = 1'b1;
                end
                pgn_pkg::MODE_LINE:
                begin
                    if (c == pgn_pkg::CharCr || c == pgn_pkg::CharLf)
                    begin
                        mode_next = pgn_pkg::MODE_IDLE;
                        count_next = '0;
                        held_char_next = 8'd0;
                        held_valid_next = 1'b0;
                    end
                end
                pgn_pkg::MODE_BRACE:
                begin
                    if (c == pgn_pkg::CharBraceClose)
                    begin
                        mode_next = pgn_pkg::MODE_IDLE;
                        count_next = '0;
                        held_char_next = 8'd0;
                        held_valid_next = 1'b0;
                    end
                end
                pgn_pkg::MODE_VARIATION:
                begin
                    if (c == pgn_pkg::CharParenOpen)
                    begin
                        if (depth_reg < pgn_pkg::DepthWidth'(pgn_pkg::DEPTH_MAX))
                            depth_next = depth_reg + 1'b1;
                    end
                    else if (c == pgn_pkg::CharParenClose)
                    begin
                        if (depth_reg != '0)
                            depth_next = depth_reg - 1'b1;
                        if (depth_next == '0)
                        begin
                            mode_next = pgn_pkg::MODE_IDLE;
                            count_next = '0;
                            held_char_next = 8'd0;
                            held_valid_next = 1'b0;
                        end
                    end
                end
                default:
                begin
                    do_start = 1'b1;
                end
            endcase

            if (do_start)
            begin
                mode_next = pgn_pkg::MODE_IDLE;
                count_next = '0;
                held_char_next = 8'd0;
                held_valid_next = 1'b0;
                if (pgn_pkg::is_space(c))
                begin
                    mode_next = pgn_pkg::MODE_IDLE;
                end
                else if (pgn_pkg::is_symbol_char(c))
                begin
                    mode_next = pgn_pkg::MODE_SYMBOL;
                    do_store = 1'b1;
                end
                else if (c == pgn_pkg::CharQuote)
                begin
                    mode_next = pgn_pkg::MODE_STRING;
                end
                else if (c == pgn_pkg::CharSemicolon)
                begin
                    mode_next = pgn_pkg::MODE_LINE;
                end
                else if (c == pgn_pkg::CharBraceOpen)
                begin
                    mode_next = pgn_pkg::MODE_BRACE;
                end
                else if (c == pgn_pkg::CharParenOpen)
                begin
                    mode_next = pgn_pkg::MODE_VARIATION;
                    depth_next = pgn_pkg::DepthWidth'(1);
                end
                else if (max_len_reg != '0)
                begin
                    res_slot[res_count[0]] = pgn_pkg::mk_result(pgn_pkg::RK_CHAR,
                        pgn_pkg::TK_PUNCT, c, 1'b1);
                    res_count = res_count + 2'd1;
                end
                else
                begin
                    res_slot[res_count[0]] = pgn_pkg::mk_result(pgn_pkg::RK_ERROR,
                        pgn_pkg::TK_SYMBOL, 8'd0, 1'b0);
                    res_count = res_count + 2'd1;
                end
            end

            if (do_store)
            begin
                held_tk = (mode_next == pgn_pkg::MODE_SYMBOL) ? pgn_pkg::TK_SYMBOL
                                                              : pgn_pkg::TK_STRING;
                if (count_next < max_len_reg)
                begin
                    count_next = count_next + 1'b1;
                    if (held_valid_next)
                    begin
                        res_slot[res_count[0]] = pgn_pkg::mk_result(pgn_pkg::RK_CHAR,
                            held_tk, held_char_next, 1'b0);
                        res_count = res_count + 2'd1;
                    end
                    held_char_next = c;
                    held_valid_next = 1'b1;
                end
                else
                begin
                    res_slot[res_count[0]] = pgn_pkg::mk_result(pgn_pkg::RK_ERROR,
                        pgn_pkg::TK_SYMBOL, 8'd0, 1'b0);
                    res_count = res_count + 2'd1;
                    mode_next = pgn_pkg::MODE_IDLE;
                    count_next = '0;
                    held_char_next = 8'd0;
                    held_valid_next = 1'b0;
                end
            end
        end

        if (res_count == 2'd2)
            res_slot[1].last = 1'b1;
        else if (res_count == 2'd1)
            res_slot[0].last = 1'b1;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next = fill_reg;
        if (accept_item)
        begin
            wr_ptr_next = wr_ptr_reg + pgn_pkg::FifoPtrWidth'(res_count);
            fill_next = fill_next + pgn_pkg::FifoCntWidth'(res_count);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
            fill_next = fill_next - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= pgn_pkg::MODE_IDLE;
            count_reg <= '0;
            held_char_reg <= 8'd0;
            held_valid_reg <= 1'b0;
            depth_reg <= '0;
            max_len_reg <= pgn_pkg::MaxLenReset;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (accept_item)
            begin
                mode_reg <= mode_next;
                count_reg <= count_next;
                held_char_reg <= held_char_next;
                held_valid_reg <= held_valid_next;
                depth_reg <= depth_next;
            end
            if (cfg_write_en)
                max_len_reg <= cfg_data;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_item)
        begin
            if (res_count != 2'd0)
                fifo_reg[wr_ptr_reg] <= res_slot[0];
            if (res_count == 2'd2)
                fifo_reg[wr_ptr_reg + 1'b1] <= res_slot[1];
        end
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= pgn_pkg::FifoCntWidth'(pgn_pkg::FifoDepth))
        else $error("result queue overfilled");

    a_held_in_token: assert property (@(posedge clk) disable iff (!rst_n)
        held_valid_reg |-> (mode_reg == pgn_pkg::MODE_SYMBOL
                            || mode_reg == pgn_pkg::MODE_STRING
                            || mode_reg == pgn_pkg::MODE_ESCAPE))
        else $error("held character outside a token");

    a_eoi_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept_item && item.end_of_input) |=>
            (mode_reg == pgn_pkg::MODE_IDLE && depth_reg == '0 && !held_valid_reg))
        else $error("scanner not idle after end of input");
`endif

endmodule
